/* sv/dgt_pkg.sv */
// shared widths, register indexes and triangle codes of the depth grid triangulator
package dgt_pkg;

    localparam int SIZE_W  = 12;
    localparam int DEPTH_W = 32;
    localparam int VTX_W   = 22;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 72;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_THRESHOLD = 2'd2;

    localparam logic [SIZE_W-1:0]  RST_FRAME_WIDTH     = 12'd1024;
    localparam logic [SIZE_W-1:0]  RST_FRAME_HEIGHT    = 12'd768;
    localparam logic [DEPTH_W-1:0] RST_DEPTH_THRESHOLD = 32'hFFFD_4CCD;

    // cell result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 4;

    typedef logic [1:0] tri_kind_t;

    // vertex orders of the four triangle shapes of a cell
    localparam tri_kind_t TRI_UL_LL_UR = 2'd0;
    localparam tri_kind_t TRI_UR_LL_LR = 2'd1;
    localparam tri_kind_t TRI_UL_LL_LR = 2'd2;
    localparam tri_kind_t TRI_UL_LR_UR = 2'd3;

    // corner mark patterns: bit0 upper left, bit1 upper right, bit2 lower left, bit3 lower right
    localparam logic [3:0] CORNERS_NONE = 4'h0;
    localparam logic [3:0] CORNER_UL    = 4'h1;
    localparam logic [3:0] CORNER_UR    = 4'h2;
    localparam logic [3:0] CORNER_LL    = 4'h4;
    localparam logic [3:0] CORNER_LR    = 4'h8;

endpackage

/* sv/dgt_ram.sv */
// generic single write port ram with registered read
module dgt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/depth_grid_triangulator_top.sv */
// depth grid triangulator top level: line store of hole marks, cell pipeline, triangle queue
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------------------
//  s_       | in        | tdata: depth[31:0]
//  m_       | out       | tdata: vertex_first, vertex_second, vertex_third (22 each);
//           |           | tlast: last_of_run
//  cfg_     | in        | write only: frame_width, frame_height, depth_threshold
//
//  one sample a cycle when it gives at most one triangle and m_tready stays high; clear cells
//  give two through the single triangle port, slowing intake; a sample's first word leaves after
//  stage 1, stage 2 and the cell queue. The mark line store is one 1-bit ram, read when a sample
//  is taken and written back in the next cycle; successive samples always touch different columns
//  aresetn is synchronous; there is no clearing pass, the first row fills the line store
//  s_tready drops when the four-entry cell queue plus samples in flight would overflow
module depth_grid_triangulator_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [dgt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dgt_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dgt_pkg::IN_TDATA_W-1:0]      s_tdata,   // depth[31:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // vertex_first[21:0], vertex_second[43:22], vertex_third[65:44], zeros[71:66]
    output logic [dgt_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast     // last_of_run
);

    localparam int CW = $clog2(MAX_WIDTH);       // column counter
    localparam int WW = $clog2(MAX_WIDTH + 1);   // effective width
    localparam int RW = $clog2(MAX_HEIGHT);      // row counter
    localparam int HW = $clog2(MAX_HEIGHT + 1);  // effective height
    localparam int VW = dgt_pkg::VTX_W;

    // configuration
    logic [dgt_pkg::SIZE_W-1:0]  frame_width_reg;
    logic [dgt_pkg::SIZE_W-1:0]  frame_height_reg;
    logic signed [dgt_pkg::DEPTH_W-1:0] depth_threshold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg     <= dgt_pkg::RST_FRAME_WIDTH;
            frame_height_reg    <= dgt_pkg::RST_FRAME_HEIGHT;
            depth_threshold_reg <= dgt_pkg::RST_DEPTH_THRESHOLD;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                dgt_pkg::CFG_FRAME_WIDTH:     frame_width_reg <= cfg_wdata[dgt_pkg::SIZE_W-1:0];
                dgt_pkg::CFG_FRAME_HEIGHT:    frame_height_reg <= cfg_wdata[dgt_pkg::SIZE_W-1:0];
                dgt_pkg::CFG_DEPTH_THRESHOLD: depth_threshold_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // saturated frame size
    logic [WW-1:0] width_eff;
    logic [HW-1:0] height_eff;

    always_comb begin
        if (frame_width_reg < 12'd3) begin
            width_eff = WW'(3);
        end else if (32'(frame_width_reg) > MAX_WIDTH) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(frame_width_reg);
        end
        if (frame_height_reg < 12'd3) begin
            height_eff = HW'(3);
        end else if (32'(frame_height_reg) > MAX_HEIGHT) begin
            height_eff = HW'(MAX_HEIGHT);
        end else begin
            height_eff = HW'(frame_height_reg);
        end
    end

    // stage 0: accept, raster position, line store read
    logic          accept;
    logic [CW-1:0] column_count_reg, column_count_next;
    logic [RW-1:0] row_count_reg, row_count_next;
    logic          mark_s0;
    logic          interior_s0;

    logic [dgt_pkg::QCNT_W-1:0] q_count_reg, q_count_next;
    logic                       valid1_reg, valid2_reg;
    logic [dgt_pkg::QCNT_W-1:0] credit_used;

    assign credit_used = q_count_reg + dgt_pkg::QCNT_W'(valid1_reg)
                         + dgt_pkg::QCNT_W'(valid2_reg);
    assign s_tready = credit_used < dgt_pkg::QCNT_W'(dgt_pkg::QDEPTH);
    assign accept   = s_tvalid && s_tready;

    assign mark_s0 = $signed(s_tdata[dgt_pkg::DEPTH_W-1:0]) < depth_threshold_reg;
    assign interior_s0 = (row_count_reg >= RW'(2)) && (column_count_reg >= CW'(2))
                         && (HW'(row_count_reg) < height_eff)
                         && (WW'(column_count_reg) < width_eff);

    always_comb begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (accept) begin
            if (WW'(column_count_reg) + WW'(1) >= width_eff) begin
                column_count_next = '0;
                if (HW'(row_count_reg) + HW'(1) >= height_eff) begin
                    row_count_next = '0;
                end else begin
                    row_count_next = row_count_reg + RW'(1);
                end
            end else begin
                column_count_next = column_count_reg + CW'(1);
            end
        end
    end

    // stage 1: corner marks, triangle choice, row base multiply
    logic          mark1_reg;
    logic          interior1_reg;
    logic [CW-1:0] col1_reg;
    logic [RW-1:0] row1_reg;
    logic [WW-1:0] width1_reg;
    logic          upper_mark;
    logic          left_mark_reg;
    logic          upper_left_mark_reg;

    dgt_ram #(
        .WIDTH (1),
        .DEPTH (MAX_WIDTH)
    ) u_row_marks (
        .aclk  (aclk),
        .we    (valid1_reg),
        .waddr (col1_reg),
        .wdata (mark1_reg),
        .re    (accept),
        .raddr (column_count_reg),
        .rdata (upper_mark)
    );

    logic [3:0]         corners;
    logic               has_tri1;
    logic               two_tri1;
    dgt_pkg::tri_kind_t kind1;

    assign corners = {mark1_reg, left_mark_reg, upper_mark, upper_left_mark_reg};

    always_comb begin
        has_tri1 = 1'b1;
        two_tri1 = 1'b0;
        kind1    = dgt_pkg::TRI_UL_LL_UR;
        unique case (corners)
            dgt_pkg::CORNERS_NONE: begin
                two_tri1 = 1'b1;
                kind1    = dgt_pkg::TRI_UL_LL_UR;
            end
            dgt_pkg::CORNER_UL: kind1 = dgt_pkg::TRI_UR_LL_LR;
            dgt_pkg::CORNER_UR: kind1 = dgt_pkg::TRI_UL_LL_LR;
            dgt_pkg::CORNER_LL: kind1 = dgt_pkg::TRI_UL_LR_UR;
            dgt_pkg::CORNER_LR: kind1 = dgt_pkg::TRI_UL_LL_UR;
            default:            has_tri1 = 1'b0;
        endcase
    end

    logic [RW+WW-1:0] row_base1;
    assign row_base1 = (RW+WW)'(row1_reg - RW'(1)) * (RW+WW)'(width1_reg);

    // stage 2: vertex index adds
    logic               has2_reg;
    logic               two2_reg;
    dgt_pkg::tri_kind_t kind2_reg;
    logic [VW-1:0]      base2_reg;
    logic [CW-1:0]      col2_reg;
    logic [WW-1:0]      width2_reg;
    logic [VW-1:0]      ul2;
    logic [VW-1:0]      ll2;

    assign ul2 = base2_reg + VW'(col2_reg) - VW'(1);
    assign ll2 = ul2 + VW'(width2_reg);

    // cell queue: one entry per meshed cell, drained one triangle a word
    logic [VW-1:0]      q_ul_reg [dgt_pkg::QDEPTH];
    logic [VW-1:0]      q_ll_reg [dgt_pkg::QDEPTH];
    dgt_pkg::tri_kind_t q_kind_reg [dgt_pkg::QDEPTH];
    logic               q_two_reg [dgt_pkg::QDEPTH];
    logic [dgt_pkg::QPTR_W-1:0] q_wr_ptr_reg, q_rd_ptr_reg;
    logic               half_reg, half_next;
    logic               push, pop, out_fire;

    assign push     = valid2_reg && has2_reg;
    assign m_tvalid = q_count_reg != '0;
    assign out_fire = m_tvalid && m_tready;
    assign m_tlast  = !q_two_reg[q_rd_ptr_reg] || half_reg;
    assign pop      = out_fire && m_tlast;

    always_comb begin
        q_count_next = q_count_reg + dgt_pkg::QCNT_W'(push) - dgt_pkg::QCNT_W'(pop);
        half_next    = half_reg;
        if (out_fire) begin
            half_next = !m_tlast;
        end
    end

    logic [VW-1:0]      h_ul, h_ll, h_ur, h_lr;
    dgt_pkg::tri_kind_t out_kind;
    logic [VW-1:0]      v_first, v_second, v_third;

    assign h_ul = q_ul_reg[q_rd_ptr_reg];
    assign h_ll = q_ll_reg[q_rd_ptr_reg];
    assign h_ur = h_ul + VW'(1);
    assign h_lr = h_ll + VW'(1);
    // the second triangle of a clear cell is always the lower right one
    assign out_kind = half_reg ? dgt_pkg::TRI_UR_LL_LR : q_kind_reg[q_rd_ptr_reg];

    always_comb begin
        case (out_kind)
            dgt_pkg::TRI_UL_LL_UR: begin
                v_first = h_ul; v_second = h_ll; v_third = h_ur;
            end
            dgt_pkg::TRI_UR_LL_LR: begin
                v_first = h_ur; v_second = h_ll; v_third = h_lr;
            end
            dgt_pkg::TRI_UL_LL_LR: begin
                v_first = h_ul; v_second = h_ll; v_third = h_lr;
            end
            default: begin
                v_first = h_ul; v_second = h_lr; v_third = h_ur;
            end
        endcase
    end

    assign m_tdata = {(dgt_pkg::OUT_TDATA_W - 3 * VW)'(0), v_third, v_second, v_first};

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg    <= '0;
            row_count_reg       <= '0;
            valid1_reg          <= 1'b0;
            valid2_reg          <= 1'b0;
            left_mark_reg       <= 1'b0;
            upper_left_mark_reg <= 1'b0;
            q_count_reg         <= '0;
            q_wr_ptr_reg        <= '0;
            q_rd_ptr_reg        <= '0;
            half_reg            <= 1'b0;
        end else begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            valid1_reg       <= accept;
            valid2_reg       <= valid1_reg;
            if (valid1_reg) begin
                left_mark_reg       <= mark1_reg;
                upper_left_mark_reg <= upper_mark;
            end
            q_count_reg <= q_count_next;
            half_reg    <= half_next;
            if (push) begin
                q_wr_ptr_reg <= q_wr_ptr_reg + dgt_pkg::QPTR_W'(1);
            end
            if (pop) begin
                q_rd_ptr_reg <= q_rd_ptr_reg + dgt_pkg::QPTR_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            mark1_reg     <= mark_s0;
            interior1_reg <= interior_s0;
            col1_reg      <= column_count_reg;
            row1_reg      <= row_count_reg;
            width1_reg    <= width_eff;
        end
        if (valid1_reg) begin
            has2_reg   <= interior1_reg && has_tri1;
            two2_reg   <= two_tri1;
            kind2_reg  <= kind1;
            base2_reg  <= VW'(row_base1);
            col2_reg   <= col1_reg;
            width2_reg <= width1_reg;
        end
        if (push) begin
            q_ul_reg[q_wr_ptr_reg]   <= ul2;
            q_ll_reg[q_wr_ptr_reg]   <= ll2;
            q_kind_reg[q_wr_ptr_reg] <= kind2_reg;
            q_two_reg[q_wr_ptr_reg]  <= two2_reg;
        end
    end

`ifndef SYNTHESIS
    // queue plus samples in flight never exceed the queue
    a_credit: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_used <= dgt_pkg::QCNT_W'(dgt_pkg::QDEPTH))
        else $error("cell queue overcommitted");

    // a push always finds room
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (q_count_reg < dgt_pkg::QCNT_W'(dgt_pkg::QDEPTH) || pop))
        else $error("cell queue overflow");

    // second half only exists for clear cells
    a_half_two: assert property (@(posedge aclk) disable iff (!aresetn)
        half_reg |-> (m_tvalid && q_two_reg[q_rd_ptr_reg]))
        else $error("second triangle of a one-triangle cell");

    // line store read and write-back never hit the same column in one cycle
    a_no_rmw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && valid1_reg) |-> (column_count_reg != col1_reg))
        else $error("line store read and write collide");

    // a clear cell leaves its second triangle right after the first is taken
    a_second_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_fire && !m_tlast) |=> (half_reg && m_tvalid))
        else $error("second triangle lost");
`endif

endmodule
